### src/dslrs_pkg.sv
// Shared types, codes and binary64 helpers for the leaving-row select unit.
package dslrs_pkg;

    localparam int ROW_W        = 12;
    localparam int DEF_MAX_ROWS = 4096;

    localparam logic [1:0] FPU_ADD = 2'd0;
    localparam logic [1:0] FPU_SUB = 2'd1;
    localparam logic [1:0] FPU_MUL = 2'd2;
    localparam logic [1:0] FPU_DIV = 2'd3;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    localparam logic [63:0] FP_POS_ZERO        = 64'h0000_0000_0000_0000;
    localparam logic [63:0] FP_POS_INF         = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] FP_QNAN            = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] WEIGHT_FLOOR_RESET = 64'h3F1A_36E2_EB1C_432D;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_fpu_rsp;

    function automatic logic fp_is_nan(input logic [63:0] v);
        return (&v[62:52]) && (|v[51:0]);
    endfunction

    function automatic logic fp_is_finite(input logic [63:0] v);
        return !(&v[62:52]);
    endfunction

    // IEEE a < b, false on any NaN, signed zeros equal
    function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
        logic res;
        if (fp_is_nan(a) || fp_is_nan(b)) begin
            res = 1'b0;
        end else if (a[62:0] == 63'd0 && b[62:0] == 63'd0) begin
            res = 1'b0;
        end else if (a[63] != b[63]) begin
            res = a[63];
        end else if (!a[63]) begin
            res = a[62:0] < b[62:0];
        end else begin
            res = a[62:0] > b[62:0];
        end
        return res;
    endfunction

endpackage

### src/dslrs_fpu.sv
// Iterative binary64 add/sub/mul/div unit with a shared normalize-and-round loop.
module dslrs_fpu import dslrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fpu_req    i_req,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output t_fpu_rsp    o_rsp
);

    localparam int MW = 108;
    localparam int EW = 14;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DPRE = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_NORM = 3'd4;

    localparam logic signed [EW-1:0] BIAS   = 14'sd1075;
    localparam logic signed [EW-1:0] EMIN   = -14'sd1074;
    localparam logic signed [EW-1:0] EXPMAX = 14'sd2046;

    logic [2:0]             r_state, n_state;
    logic                   r_sign, n_sign;
    logic [MW-1:0]          r_m, n_m;
    logic signed [EW-1:0]   r_e, n_e;
    logic                   r_g, n_g;
    logic                   r_st, n_st;
    logic [52:0]            r_a, n_a;
    logic [52:0]            r_b, n_b;
    logic [53:0]            r_r, n_r;
    logic [5:0]             r_cnt, n_cnt;
    logic [63:0]            r_res, n_res;
    logic                   r_done, n_done;

    // operand unpack
    logic                   a_s, b_s;
    logic [10:0]            a_x, b_x;
    logic                   a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [52:0]            a_sig, b_sig;
    logic signed [EW-1:0]   a_e, b_e;
    logic                   p_s;

    assign a_s    = i_a[63];
    assign b_s    = i_b[63] ^ (i_req.op == FPU_SUB);
    assign a_x    = i_a[62:52];
    assign b_x    = i_b[62:52];
    assign a_nan  = fp_is_nan(i_a);
    assign b_nan  = fp_is_nan(i_b);
    assign a_inf  = (&a_x) && !(|i_a[51:0]);
    assign b_inf  = (&b_x) && !(|i_b[51:0]);
    assign a_zero = (i_a[62:0] == 63'd0);
    assign b_zero = (i_b[62:0] == 63'd0);
    assign a_sig  = {|a_x, i_a[51:0]};
    assign b_sig  = {|b_x, i_b[51:0]};
    assign a_e    = $signed({3'b000, ((a_x == 11'd0) ? 11'd1 : a_x)}) - BIAS;
    assign b_e    = $signed({3'b000, ((b_x == 11'd0) ? 11'd1 : b_x)}) - BIAS;
    assign p_s    = i_a[63] ^ i_b[63];

    // add path: larger magnitude first, align the smaller with a sticky bit
    logic                   a_big;
    logic [52:0]            g_sig, l_sig;
    logic signed [EW-1:0]   g_e, l_e, add_d;
    logic                   g_s, l_s;
    logic [5:0]             shamt;
    logic [55:0]            l_ext, l_sh, l_al;
    logic                   l_lost;
    logic [56:0]            add_sum;
    logic                   add_sign;

    assign a_big   = i_a[62:0] >= i_b[62:0];
    assign g_sig   = a_big ? a_sig : b_sig;
    assign l_sig   = a_big ? b_sig : a_sig;
    assign g_e     = a_big ? a_e : b_e;
    assign l_e     = a_big ? b_e : a_e;
    assign g_s     = a_big ? a_s : b_s;
    assign l_s     = a_big ? b_s : a_s;
    assign add_d   = g_e - l_e;
    assign shamt   = (add_d > 14'sd63) ? 6'd63 : add_d[5:0];
    assign l_ext   = {l_sig, 3'b000};
    assign l_sh    = l_ext >> shamt;
    assign l_lost  = |(l_ext & ~({56{1'b1}} << shamt));
    assign l_al    = {l_sh[55:1], l_sh[0] | l_lost};
    assign add_sum = (g_s == l_s) ? ({1'b0, g_sig, 3'b000} + {1'b0, l_al})
                                  : ({1'b0, g_sig, 3'b000} - {1'b0, l_al});
    assign add_sign = (add_sum == 57'd0 && g_s != l_s) ? 1'b0 : g_s;

    // divide step
    logic                   d_ge;
    logic [53:0]            d_rem;

    assign d_ge  = r_r >= {1'b0, r_b};
    assign d_rem = d_ge ? (r_r - {1'b0, r_b}) : r_r;

    // round to nearest even and pack
    logic                   rnd_inc;
    logic [53:0]            rnd_sum;
    logic signed [EW-1:0]   rnd_e, rnd_biased;
    logic [52:0]            rnd_sig;
    logic [63:0]            rnd_word;

    assign rnd_inc    = r_g & (r_st | r_m[0]);
    assign rnd_sum    = {1'b0, r_m[52:0]} + {53'd0, rnd_inc};
    assign rnd_e      = rnd_sum[53] ? (r_e + 14'sd1) : r_e;
    assign rnd_sig    = rnd_sum[53] ? rnd_sum[53:1] : rnd_sum[52:0];
    assign rnd_biased = rnd_e + BIAS;
    assign rnd_word   = (rnd_biased > EXPMAX) ? {r_sign, FP_POS_INF[62:0]}
                      : {r_sign, (rnd_sig[52] ? rnd_biased[10:0] : 11'd0), rnd_sig[51:0]};

    always_comb begin
        n_state = r_state;
        n_sign  = r_sign;
        n_m     = r_m;
        n_e     = r_e;
        n_g     = r_g;
        n_st    = r_st;
        n_a     = r_a;
        n_b     = r_b;
        n_r     = r_r;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    n_g  = 1'b0;
                    n_st = 1'b0;
                    case (i_req.op)
                        FPU_ADD, FPU_SUB: begin
                            if (a_nan || b_nan || (a_inf && b_inf && a_s != b_s)) begin
                                n_res  = FP_QNAN;
                                n_done = 1'b1;
                            end else if (a_inf) begin
                                n_res  = {a_s, FP_POS_INF[62:0]};
                                n_done = 1'b1;
                            end else if (b_inf) begin
                                n_res  = {b_s, FP_POS_INF[62:0]};
                                n_done = 1'b1;
                            end else begin
                                n_m     = MW'(add_sum);
                                n_e     = g_e - 14'sd3;
                                n_sign  = add_sign;
                                n_state = ST_NORM;
                            end
                        end
                        FPU_MUL: begin
                            if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
                                n_res  = FP_QNAN;
                                n_done = 1'b1;
                            end else if (a_inf || b_inf) begin
                                n_res  = {p_s, FP_POS_INF[62:0]};
                                n_done = 1'b1;
                            end else begin
                                n_a     = a_sig;
                                n_b     = b_sig;
                                n_m     = '0;
                                n_cnt   = 6'd52;
                                n_e     = a_e + b_e;
                                n_sign  = p_s;
                                n_state = ST_MUL;
                            end
                        end
                        default: begin
                            if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                                n_res  = FP_QNAN;
                                n_done = 1'b1;
                            end else if (a_inf || b_zero) begin
                                n_res  = {p_s, FP_POS_INF[62:0]};
                                n_done = 1'b1;
                            end else if (b_inf || a_zero) begin
                                n_res  = {p_s, 63'd0};
                                n_done = 1'b1;
                            end else begin
                                n_a     = a_sig;
                                n_b     = b_sig;
                                n_e     = a_e - b_e;
                                n_sign  = p_s;
                                n_state = ST_DPRE;
                            end
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_m   = (r_m << 1) + (r_b[r_cnt] ? MW'(r_a) : MW'(0));
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = ST_NORM;
                end
            end
            ST_DPRE: begin
                if (r_a[52] && r_b[52]) begin
                    n_r     = {1'b0, r_a};
                    n_m     = '0;
                    n_cnt   = 6'd55;
                    n_e     = r_e - 14'sd56;
                    n_state = ST_DIV;
                end else if (!r_a[52] && !r_b[52]) begin
                    n_a = {r_a[51:0], 1'b0};
                    n_b = {r_b[51:0], 1'b0};
                end else if (!r_a[52]) begin
                    n_a = {r_a[51:0], 1'b0};
                    n_e = r_e - 14'sd1;
                end else begin
                    n_b = {r_b[51:0], 1'b0};
                    n_e = r_e + 14'sd1;
                end
            end
            ST_DIV: begin
                n_r   = {d_rem[52:0], 1'b0};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    // last quotient bit, then the remainder as sticky
                    n_m     = {r_m[MW-3:0], d_ge, |d_rem};
                    n_state = ST_NORM;
                end else begin
                    n_m = {r_m[MW-2:0], d_ge};
                end
            end
            ST_NORM: begin
                if (r_m == '0 && !r_g && !r_st) begin
                    n_res   = {r_sign, 63'd0};
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_e < EMIN && r_m == '0) begin
                    // only rounding bits left below the subnormal range
                    n_st = r_st | r_g;
                    n_g  = 1'b0;
                    n_e  = EMIN;
                end else if ((|r_m[MW-1:53]) || r_e < EMIN) begin
                    n_st = r_st | r_g;
                    n_g  = r_m[0];
                    n_m  = r_m >> 1;
                    n_e  = r_e + 14'sd1;
                end else if (!r_m[52] && r_e > EMIN) begin
                    n_m = r_m << 1;
                    n_e = r_e - 14'sd1;
                end else begin
                    n_res   = rnd_word;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_sign <= n_sign;
        r_m    <= n_m;
        r_e    <= n_e;
        r_g    <= n_g;
        r_st   <= n_st;
        r_a    <= n_a;
        r_b    <= n_b;
        r_r    <= n_r;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

### src/dual_simplex_leaving_row_select_unit.sv
// Leaving-row selection for the dual simplex: scans rows, keeps the best merit.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+---------------------------------------
//  s row    | in  | i_s_tvalid/o_s_tready  | tdata: basic, lower, upper, weight; tlast
//  m result | out | o_m_tvalid/i_m_tready  | tdata: found, best_row, direction, violation
//  cfg      | in  | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// Per row, up to four add/sub, one square and one divide run one after another
// on the single iterative float unit.
// The row input is not ready while a row is in work; a result waiting in the output
// register does not block intake, only the closing of the next scan.
// Reset is synchronous, active low, and clears the scan and loads default registers.
module dual_simplex_leaving_row_select_unit import dslrs_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [255:0] i_s_tdata,   // basic_value, lower_bound, upper_bound, edge_weight
    input  logic         i_s_tlast,   // last_row
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [79:0]  o_m_tdata,   // found, best_row, direction, violation, pad
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data
);

    localparam int CNT_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PW    = (CNT_W > ROW_W) ? CNT_W : ROW_W;

    localparam logic [1:0] REG_TOL   = 2'd0;
    localparam logic [1:0] REG_FLOOR = 2'd1;
    localparam logic [1:0] REG_RULE  = 2'd2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LO_T = 4'd1;
    localparam logic [3:0] S_LO_V = 4'd2;
    localparam logic [3:0] S_HI_T = 4'd3;
    localparam logic [3:0] S_HI_V = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_CMP  = 4'd7;
    localparam logic [3:0] S_END  = 4'd8;

    logic [63:0]      r_tol, r_floor;
    logic             r_rule;
    logic [3:0]       r_state, n_state;
    logic             r_issued, n_issued;
    logic [63:0]      r_x, r_lo, r_hi, r_w;
    logic             r_last;
    logic [63:0]      r_viol, n_viol;
    logic [1:0]       r_dir, n_dir;
    logic [63:0]      r_tmp, n_tmp;
    logic [CNT_W-1:0] r_row_cnt, n_row_cnt;
    logic [63:0]      r_best_merit, n_best_merit;
    logic [CNT_W-1:0] r_best_pos, n_best_pos;
    logic [1:0]       r_best_dir, n_best_dir;
    logic [63:0]      r_best_viol, n_best_viol;
    logic             r_have_best, n_have_best;
    logic             r_out_valid, n_out_valid;
    logic [79:0]      r_out_data, n_out_data;

    t_fpu_req         fpu_req;
    t_fpu_rsp         fpu_rsp;
    logic [63:0]      fpu_a, fpu_b;
    logic             issue;
    logic [63:0]      w_eff;
    logic             s_accept, out_free;
    logic [PW-1:0]    pos_ext;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign w_eff    = fp_lt(r_w, r_floor) ? r_floor : r_w;
    assign pos_ext  = PW'(r_best_pos);

    dslrs_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .i_a     (fpu_a),
        .i_b     (fpu_b),
        .o_rsp   (fpu_rsp)
    );

    // operand routing for the float unit
    always_comb begin
        fpu_req.start = issue;
        fpu_a = r_tmp;
        fpu_b = w_eff;
        fpu_req.op = FPU_DIV;
        case (r_state)
            S_LO_T: begin
                fpu_a = r_lo;  fpu_b = r_tol;  fpu_req.op = FPU_SUB;
            end
            S_LO_V: begin
                fpu_a = r_lo;  fpu_b = r_x;    fpu_req.op = FPU_SUB;
            end
            S_HI_T: begin
                fpu_a = r_hi;  fpu_b = r_tol;  fpu_req.op = FPU_ADD;
            end
            S_HI_V: begin
                fpu_a = r_x;   fpu_b = r_hi;   fpu_req.op = FPU_SUB;
            end
            S_MUL: begin
                fpu_a = r_viol; fpu_b = r_viol; fpu_req.op = FPU_MUL;
            end
            default: begin
                fpu_a = r_tmp; fpu_b = w_eff;  fpu_req.op = FPU_DIV;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_issued     = r_issued;
        n_viol       = r_viol;
        n_dir        = r_dir;
        n_tmp        = r_tmp;
        n_row_cnt    = r_row_cnt;
        n_best_merit = r_best_merit;
        n_best_pos   = r_best_pos;
        n_best_dir   = r_best_dir;
        n_best_viol  = r_best_viol;
        n_have_best  = r_have_best;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        issue        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_viol  = FP_POS_ZERO;
                    n_dir   = DIR_NONE;
                    n_state = S_LO_T;
                end
            end
            S_LO_T: begin
                if (!fp_is_finite(r_lo)) begin
                    n_state = S_HI_T;
                end else if (!r_issued) begin
                    issue    = 1'b1;
                    n_issued = 1'b1;
                end else if (fpu_rsp.done) begin
                    n_issued = 1'b0;
                    n_state  = fp_lt(r_x, fpu_rsp.result) ? S_LO_V : S_HI_T;
                end
            end
            S_LO_V: begin
                if (!r_issued) begin
                    issue    = 1'b1;
                    n_issued = 1'b1;
                end else if (fpu_rsp.done) begin
                    n_issued = 1'b0;
                    n_viol   = fpu_rsp.result;
                    n_dir    = DIR_UP;
                    n_state  = S_HI_T;
                end
            end
            S_HI_T: begin
                if (!fp_is_finite(r_hi)) begin
                    n_state = S_MUL;
                end else if (!r_issued) begin
                    issue    = 1'b1;
                    n_issued = 1'b1;
                end else if (fpu_rsp.done) begin
                    n_issued = 1'b0;
                    n_state  = fp_lt(fpu_rsp.result, r_x) ? S_HI_V : S_MUL;
                end
            end
            S_HI_V: begin
                if (!r_issued) begin
                    issue    = 1'b1;
                    n_issued = 1'b1;
                end else if (fpu_rsp.done) begin
                    n_issued = 1'b0;
                    if (fp_lt(r_viol, fpu_rsp.result)) begin
                        n_viol = fpu_rsp.result;
                        n_dir  = DIR_DOWN;
                    end
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (!fp_lt(FP_POS_ZERO, r_viol)) begin
                    n_state = S_END;
                end else if (!r_issued) begin
                    issue    = 1'b1;
                    n_issued = 1'b1;
                end else if (fpu_rsp.done) begin
                    n_issued = 1'b0;
                    n_tmp    = fpu_rsp.result;
                    n_state  = r_rule ? S_DIV : S_CMP;
                end
            end
            S_DIV: begin
                if (w_eff[62:0] == 63'd0) begin
                    // zero weight: a positive zero gives infinite merit, a negative one none
                    n_tmp   = (!w_eff[63] && fp_lt(FP_POS_ZERO, r_tmp)) ? FP_POS_INF
                                                                        : FP_POS_ZERO;
                    n_state = S_CMP;
                end else if (!r_issued) begin
                    issue    = 1'b1;
                    n_issued = 1'b1;
                end else if (fpu_rsp.done) begin
                    n_issued = 1'b0;
                    n_tmp    = fpu_rsp.result;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                if (fp_lt(r_best_merit, r_tmp)) begin
                    n_best_merit = r_tmp;
                    n_best_pos   = r_row_cnt;
                    n_best_dir   = r_dir;
                    n_best_viol  = r_viol;
                    n_have_best  = 1'b1;
                end
                n_state = S_END;
            end
            S_END: begin
                if (!r_last) begin
                    n_row_cnt = (r_row_cnt == CNT_W'(MAX_ROWS - 1)) ? '0
                                                                    : r_row_cnt + 1'b1;
                    n_state   = S_IDLE;
                end else if (out_free) begin
                    // close the scan: publish and clear
                    n_out_valid = 1'b1;
                    if (r_have_best) begin
                        n_out_data = {1'b0, r_best_viol, r_best_dir, pos_ext[ROW_W-1:0], 1'b1};
                    end else begin
                        n_out_data = {1'b0, FP_POS_ZERO, DIR_NONE, {ROW_W{1'b0}}, 1'b0};
                    end
                    n_row_cnt    = '0;
                    n_best_merit = FP_POS_ZERO;
                    n_best_pos   = '0;
                    n_best_dir   = DIR_NONE;
                    n_best_viol  = FP_POS_ZERO;
                    n_have_best  = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol        <= FP_POS_ZERO;
            r_floor      <= WEIGHT_FLOOR_RESET;
            r_rule       <= 1'b1;
            r_state      <= S_IDLE;
            r_issued     <= 1'b0;
            r_row_cnt    <= '0;
            r_best_merit <= FP_POS_ZERO;
            r_best_pos   <= '0;
            r_best_dir   <= DIR_NONE;
            r_best_viol  <= FP_POS_ZERO;
            r_have_best  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TOL:   r_tol   <= i_cfg_data;
                    REG_FLOOR: r_floor <= i_cfg_data;
                    REG_RULE:  r_rule  <= i_cfg_data[0];
                    default:   ;
                endcase
            end
            r_state      <= n_state;
            r_issued     <= n_issued;
            r_row_cnt    <= n_row_cnt;
            r_best_merit <= n_best_merit;
            r_best_pos   <= n_best_pos;
            r_best_dir   <= n_best_dir;
            r_best_viol  <= n_best_viol;
            r_have_best  <= n_have_best;
            r_out_valid  <= n_out_valid;
        end
        if (s_accept) begin
            r_x    <= i_s_tdata[63:0];
            r_lo   <= i_s_tdata[127:64];
            r_hi   <= i_s_tdata[191:128];
            r_w    <= i_s_tdata[255:192];
            r_last <= i_s_tlast;
        end
        r_viol     <= n_viol;
        r_dir      <= n_dir;
        r_tmp      <= n_tmp;
        r_out_data <= n_out_data;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_done_needs_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_rsp.done |-> r_issued)
        else $error("float unit finished without a pending request");

    a_best_dir_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_best |-> (r_best_dir == DIR_UP || r_best_dir == DIR_DOWN))
        else $error("kept row has no direction");

    a_no_best_zero_merit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_best |-> (r_best_merit == FP_POS_ZERO))
        else $error("merit kept without a candidate row");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[79:1] == 79'd0))
        else $error("result without a row carries data");
`endif

endmodule
